// ----- hw/rtl/pld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_pkg: shared types and constants of the presence LED dimmer.
// Holds the payload structs, the sequencer states, the lamp modes, the
// register indexes, the reciprocal constants and the gamma table.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int unsigned FULL_LEVEL = 25600;
  localparam int unsigned SNAP_LEVEL = 26;
  localparam int unsigned DUTY_BITS  = 10;

  // Reciprocal of 125 scaled by 2^30, exact for dividends below 2^23.
  localparam logic [23:0] EMA_RECIP   = 24'd8589935;
  // Reciprocal of 25 scaled by 2^22, exact for dividends below 2^17.
  localparam logic [17:0] BLEND_RECIP = 18'd167773;

  typedef struct packed {
    logic        command;
    logic [15:0] distance_mm;
    logic        reading_valid;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic [1:0]           mode;
    logic                 duty_updated;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_TRACK = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_FADE  = 2'd2
  } lamp_mode_t;

  typedef enum logic [2:0] {
    REG_FULL_BRIGHT = 3'd0,
    REG_FULL_DIM    = 3'd1,
    REG_TRACK_STEP  = 3'd2,
    REG_HOLD_TICKS  = 3'd3,
    REG_INV_LIMIT   = 3'd4,
    REG_FADE_FAST   = 3'd5,
    REG_FADE_SLOW   = 3'd6,
    REG_SLOW_LEVEL  = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MED,
    ST_EMA_MUL1,
    ST_EMA_MUL2,
    ST_EMA_DIV,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_TICK,
    ST_FADE_MUL,
    ST_GAMMA_MUL,
    ST_GAMMA_DIV,
    ST_DUTY_MUL,
    ST_OUT
  } seq_state_t;

  // Divider request: unsigned dividend over divisor.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [16:0] gamma_lut(input logic [5:0] idx);
    logic [16:0] v;
    unique case (idx)
      6'd0: v = 17'd0;         6'd1: v = 17'd32;
      6'd2: v = 17'd147;       6'd3: v = 17'd359;
      6'd4: v = 17'd676;       6'd5: v = 17'd1104;
      6'd6: v = 17'd1648;      6'd7: v = 17'd2314;
      6'd8: v = 17'd3104;      6'd9: v = 17'd4022;
      6'd10: v = 17'd5072;     6'd11: v = 17'd6255;
      6'd12: v = 17'd7574;     6'd13: v = 17'd9033;
      6'd14: v = 17'd10632;    6'd15: v = 17'd12375;
      6'd16: v = 17'd14263;    6'd17: v = 17'd16298;
      6'd18: v = 17'd18482;    6'd19: v = 17'd20817;
      6'd20: v = 17'd23303;    6'd21: v = 17'd25944;
      6'd22: v = 17'd28740;    6'd23: v = 17'd31692;
      6'd24: v = 17'd34803;    6'd25: v = 17'd38073;
      6'd26: v = 17'd41504;    6'd27: v = 17'd45097;
      6'd28: v = 17'd48854;    6'd29: v = 17'd52775;
      6'd30: v = 17'd56861;    6'd31: v = 17'd61115;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/pld_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pld_divider: shared restoring divider.
// Produces one quotient bit per cycle for a 32-bit dividend and a 16-bit
// divisor; the quotient is valid when busy falls.
// ----------------------------------------------------------------------------
module pld_divider (
  input  logic               clk,
  input  logic               rst,
  input  pld_pkg::div_req_t  req,
  output pld_pkg::div_rsp_t  rsp
);

  logic [31:0] quot;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [16:0] trial;

  // One restoring step on the next dividend bit.
  always_comb begin
    trial = {rem[15:0], quot[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= 6'd32;
      quot  <= req.dividend;
      rem   <= '0;
      dvs   <= req.divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= trial - {1'b0, dvs};
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[30:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quot;

endmodule

// ----- hw/rtl/presence_led_dimmer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presence_led_dimmer_unit: presence-driven LED dimmer.
// A valid reading stalls the input while it is filtered and mapped, and for
// longer when the mapping needs the shared divider; an invalid reading does
// not stall it. A tick stalls the input through its gamma and duty states,
// and a fade step when fading; its result is valid once the stall ends, and
// a result held by the receiver only stalls the next tick. Reset clears the
// block state, loads the register defaults and empties the result register.
// ----------------------------------------------------------------------------
module presence_led_dimmer_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  pld_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output pld_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam logic [pld_pkg::DUTY_BITS-1:0] DUTY_MAX = {pld_pkg::DUTY_BITS{1'b1}};

  // Configuration registers.
  logic [15:0] full_bright, full_dim, hold_ticks, fade_fast, fade_slow;
  logic [14:0] step_max, slow_level;
  logic [3:0]  inv_limit;

  // Block state.
  logic [15:0] win0, win1, win2;
  logic [1:0]  win_pos;
  logic [15:0] smoothed;
  logic        seeded;
  logic [14:0] target_level, cur_level;
  logic        have_valid;
  logic [3:0]  inv_run;
  logic [15:0] ticks_since;
  pld_pkg::lamp_mode_t lamp_mode;
  logic        wrote;

  // Working registers.
  pld_pkg::seq_state_t state, state_next;
  logic [15:0] med;
  logic [31:0] acc;
  logic [pld_pkg::DUTY_BITS-1:0] prod;
  logic [16:0] g_base;
  logic [9:0]  g_rem;
  logic [16:0] gval;

  // Result register.
  logic               out_full;
  pld_pkg::out_item_t out_reg;

  pld_pkg::div_req_t div_req;
  pld_pkg::div_rsp_t div_rsp;

  pld_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Shared multiplier operands.
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Median of the window, absolute change and alpha.
  logic [15:0] hi, lo, med_c;
  logic [15:0] dmag;
  logic [9:0]  alpha;
  logic [17:0] alpha_raw;
  logic [14:0] lvl_c;
  logic [15:0] lvl_seg;
  logic [5:0]  g_idx;
  logic [16:0] g_lo, g_hi;

  always_comb begin
    hi = (win0 > win1) ? win0 : win1;
    lo = (win0 > win1) ? win1 : win0;
    if (win2 >= hi) med_c = hi;
    else if (win2 <= lo) med_c = lo;
    else med_c = win2;
    dmag = (med > smoothed) ? med - smoothed : smoothed - med;
    alpha_raw = 18'd150 + 18'(dmag) * 18'd3;
    alpha = (alpha_raw > 18'd1000) ? 10'd1000 : alpha_raw[9:0];
    lvl_c = (cur_level > 15'(pld_pkg::FULL_LEVEL)) ? 15'(pld_pkg::FULL_LEVEL)
                                                    : cur_level;
    // Segment index: level / 800 as (level / 32) * 41 / 1024.
    lvl_seg = 16'(lvl_c[14:5]) * 16'd41;
    g_idx = lvl_seg[15:10];
    g_lo  = pld_pkg::gamma_lut(g_idx);
    g_hi  = pld_pkg::gamma_lut(g_idx + 6'd1);
  end

  // Constant divisions by reciprocal multiplication: the smoother sum over
  // 1000 and the gamma blend product over 800.
  logic [22:0] ema_x;
  logic [46:0] ema_prod;
  logic [16:0] blend_x;
  logic [34:0] blend_prod;

  always_comb begin
    ema_x      = acc[25:3];
    ema_prod   = 47'(ema_x) * 47'(pld_pkg::EMA_RECIP);
    blend_x    = acc[21:5];
    blend_prod = 35'(blend_x) * 35'(pld_pkg::BLEND_RECIP);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      pld_pkg::ST_EMA_MUL1: begin mul_a = {6'd0, alpha}; mul_b = med; end
      pld_pkg::ST_EMA_MUL2: begin mul_a = 16'(10'd1000 - alpha); mul_b = smoothed; end
      pld_pkg::ST_MAP_MUL:  begin mul_a = full_dim - smoothed; mul_b = 16'd25600; end
      pld_pkg::ST_FADE_MUL: begin
        mul_a = {1'b0, cur_level};
        mul_b = (cur_level < slow_level) ? fade_slow : fade_fast;
      end
      pld_pkg::ST_GAMMA_MUL: begin mul_a = 16'(g_hi - g_lo); mul_b = {6'd0, g_rem}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pld_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.command) state_next = pld_pkg::ST_TICK;
          else if (in_data.reading_valid) state_next = pld_pkg::ST_MED;
        end
      end
      pld_pkg::ST_MED:      state_next = pld_pkg::ST_EMA_MUL1;
      pld_pkg::ST_EMA_MUL1: state_next = pld_pkg::ST_EMA_MUL2;
      pld_pkg::ST_EMA_MUL2: state_next = pld_pkg::ST_EMA_DIV;
      pld_pkg::ST_EMA_DIV:  state_next = pld_pkg::ST_MAP_MUL;
      pld_pkg::ST_MAP_MUL: begin
        if (smoothed <= full_bright || smoothed >= full_dim) state_next = pld_pkg::ST_IDLE;
        else state_next = pld_pkg::ST_MAP_DIV;
      end
      pld_pkg::ST_MAP_DIV:
        if (!div_rsp.busy && !div_req.start) state_next = pld_pkg::ST_IDLE;
      pld_pkg::ST_TICK: begin
        if (lamp_mode == pld_pkg::MODE_FADE && !have_valid)
          state_next = pld_pkg::ST_FADE_MUL;
        else state_next = pld_pkg::ST_GAMMA_MUL;
      end
      pld_pkg::ST_FADE_MUL:  state_next = pld_pkg::ST_GAMMA_MUL;
      pld_pkg::ST_GAMMA_MUL: state_next = pld_pkg::ST_GAMMA_DIV;
      pld_pkg::ST_GAMMA_DIV: state_next = pld_pkg::ST_DUTY_MUL;
      pld_pkg::ST_DUTY_MUL:  state_next = pld_pkg::ST_OUT;
      pld_pkg::ST_OUT: if (!out_full || !out_stall) state_next = pld_pkg::ST_IDLE;
      default: state_next = pld_pkg::ST_IDLE;
    endcase
  end

  // Handshake and divider start outputs.
  logic div_started;
  always_comb begin
    in_stall  = (state != pld_pkg::ST_IDLE);
    cfg_ready = (state == pld_pkg::ST_IDLE);
    div_req.start    = (state == pld_pkg::ST_MAP_DIV) && !div_started;
    div_req.dividend = acc;
    div_req.divisor  = full_dim - full_bright;
  end

  // Product of the blended gamma value and the duty range.
  logic [16+pld_pkg::DUTY_BITS-1:0] duty_prod;
  assign duty_prod = (16+pld_pkg::DUTY_BITS)'(gval) * (16+pld_pkg::DUTY_BITS)'(DUTY_MAX);

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pld_pkg::ST_IDLE;
      full_bright  <= 16'd500;
      full_dim     <= 16'd3000;
      step_max     <= 15'd512;
      hold_ticks   <= 16'd500;
      inv_limit    <= 4'd6;
      fade_fast    <= 16'd62915;
      fade_slow    <= 16'd64553;
      slow_level   <= 15'd3840;
      win0 <= '0; win1 <= '0; win2 <= '0;
      win_pos      <= '0;
      smoothed     <= '0;
      seeded       <= 1'b0;
      target_level <= '0;
      cur_level    <= '0;
      have_valid   <= 1'b0;
      inv_run      <= '0;
      ticks_since  <= '0;
      lamp_mode    <= pld_pkg::MODE_HOLD;
      wrote        <= 1'b0;
      div_started  <= 1'b0;
      out_full     <= 1'b0;
    end else begin
      state <= state_next;
      div_started <= div_req.start ? 1'b1 :
                     (state_next != state) ? 1'b0 : div_started;

      if (cfg_valid && cfg_ready) begin
        unique case (pld_pkg::reg_index_t'(cfg_index))
          pld_pkg::REG_FULL_BRIGHT: full_bright <= cfg_data;
          pld_pkg::REG_FULL_DIM:    full_dim    <= cfg_data;
          pld_pkg::REG_TRACK_STEP:  step_max    <= cfg_data[14:0];
          pld_pkg::REG_HOLD_TICKS:  hold_ticks  <= cfg_data;
          pld_pkg::REG_INV_LIMIT:   inv_limit   <= cfg_data[3:0];
          pld_pkg::REG_FADE_FAST:   fade_fast   <= cfg_data;
          pld_pkg::REG_FADE_SLOW:   fade_slow   <= cfg_data;
          pld_pkg::REG_SLOW_LEVEL:  slow_level  <= cfg_data[14:0];
          default: ;
        endcase
      end

      unique case (state)
        pld_pkg::ST_IDLE: begin
          if (in_valid && !in_data.command) begin
            if (in_data.reading_valid) begin
              inv_run <= '0;
              ticks_since <= '0;
              have_valid <= 1'b1;
              unique case (win_pos)
                2'd0: win0 <= in_data.distance_mm;
                2'd1: win1 <= in_data.distance_mm;
                default: win2 <= in_data.distance_mm;
              endcase
              win_pos <= (win_pos >= 2'd2) ? 2'd0 : win_pos + 2'd1;
            end else begin
              if (inv_run != 4'd15) begin
                inv_run <= inv_run + 4'd1;
                if (inv_run + 4'd1 >= inv_limit) have_valid <= 1'b0;
              end else if (inv_run >= inv_limit) begin
                have_valid <= 1'b0;
              end
            end
          end
        end
        pld_pkg::ST_MED: begin
          med <= med_c;
          if (!seeded) begin
            smoothed <= med_c;
            seeded <= 1'b1;
          end
        end
        pld_pkg::ST_EMA_MUL1: acc <= mul_p;
        pld_pkg::ST_EMA_MUL2: acc <= acc + mul_p + 32'd500;
        pld_pkg::ST_EMA_DIV:  smoothed <= ema_prod[45:30];
        pld_pkg::ST_MAP_MUL: begin
          acc <= mul_p;
          if (smoothed <= full_bright) target_level <= 15'(pld_pkg::FULL_LEVEL);
          else if (smoothed >= full_dim) target_level <= '0;
        end
        pld_pkg::ST_MAP_DIV:
          if (state_next != state) target_level <= div_rsp.quotient[14:0];
        pld_pkg::ST_TICK: begin
          wrote <= (lamp_mode == pld_pkg::MODE_TRACK) && have_valid;
          if (ticks_since != 16'hFFFF) ticks_since <= ticks_since + 16'd1;
          unique case (lamp_mode)
            pld_pkg::MODE_TRACK: begin
              if (!have_valid) lamp_mode <= pld_pkg::MODE_HOLD;
              else begin
                if (target_level > cur_level &&
                    target_level - cur_level > step_max)
                  cur_level <= cur_level + step_max;
                else if (cur_level > target_level &&
                         cur_level - target_level > step_max)
                  cur_level <= cur_level - step_max;
                else cur_level <= target_level;
              end
            end
            pld_pkg::MODE_FADE: begin
              if (have_valid) lamp_mode <= pld_pkg::MODE_TRACK;
            end
            default: begin
              if (have_valid) lamp_mode <= pld_pkg::MODE_TRACK;
              else if (((ticks_since != 16'hFFFF) ? ticks_since + 16'd1
                                                   : ticks_since) > hold_ticks)
                lamp_mode <= pld_pkg::MODE_FADE;
            end
          endcase
        end
        pld_pkg::ST_FADE_MUL: begin
          cur_level <= (mul_p[31:16] < 16'(pld_pkg::SNAP_LEVEL)) ? 15'd0
                                                                 : mul_p[30:16];
          wrote <= 1'b1;
        end
        pld_pkg::ST_GAMMA_MUL: begin
          acc <= mul_p;
          g_base <= g_lo;
        end
        pld_pkg::ST_GAMMA_DIV: gval <= g_base + 17'(blend_prod[34:22]);
        pld_pkg::ST_DUTY_MUL:  prod <= duty_prod[16 +: pld_pkg::DUTY_BITS];
        default: ;
      endcase

      // Result register: loaded when the sequencer leaves its output state,
      // emptied when the receiver takes the transaction.
      if (state == pld_pkg::ST_OUT && state_next == pld_pkg::ST_IDLE) begin
        out_full             <= 1'b1;
        out_reg.duty         <= prod;
        out_reg.mode         <= lamp_mode;
        out_reg.duty_updated <= wrote;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  // Remainder of the level within its gamma segment.
  always_comb begin
    g_rem = 10'(lvl_c - 15'(g_idx) * 15'd800);
  end

  assign out_valid = out_full;
  assign out_data  = out_reg;

endmodule
